// ===== hdl/dps_pkg.sv =====
// Shared types and constants for the dynamic priority scheduler.
package dps_pkg;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic signed [15:0] PRIO_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_WRITE
	} state_t;

	// one table entry as held in the entry memory
	typedef struct packed {
		logic signed [15:0] run_time;
		logic signed [15:0] prio;
	} entry_t;

	typedef struct packed {
		logic [3:0]         picked_slot;
		logic               idle;
		logic signed [15:0] time_left;
		logic signed [15:0] new_priority;
		logic               finished;
	} res_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} ctl_stat_t;

endpackage

// ===== hdl/dps_mem.sv =====
// Entry memory: one write port, one read port, registered read data.
module dps_mem import dps_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/dps_ctrl.sv =====
// Scheduler sequencer: ready marks, slot scan, best-entry tracking, write-back.
module dps_ctrl import dps_pkg::*; #(
	parameter int MAX_PROCS = 16,
	parameter int AW        = 4,
	parameter int NW        = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	input  logic               start,
	input  logic               mode,
	input  logic [3:0]         slot,
	input  logic signed [15:0] run_time,
	input  logic signed [15:0] priority_req,
	output ctl_stat_t          stat,
	output res_t               res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output entry_t             mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr,
	input  entry_t             mem_rdata
);

	state_t state_q, state_d;

	logic [4:0]           active_slots_q;
	logic [NW-1:0]        n_clamp;
	logic [NW-1:0]        n_q;
	logic [AW-1:0]        cnt_q;
	logic                 scan_last;
	logic [MAX_PROCS-1:0] ready_q;

	logic                 vld_s1;
	logic                 rdy_s1;
	logic [AW-1:0]        idx_s1;

	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	logic signed [15:0]   best_time_q;
	logic signed [15:0]   best_prio_q;
	logic                 take;

	logic signed [15:0]   t_new;
	logic signed [15:0]   p_new;
	logic                 fin;
	logic                 load_ok;
	logic                 load_go;
	logic                 tick_go;

	always_comb begin
		if (32'(active_slots_q) > MAX_PROCS) begin
			n_clamp = NW'(MAX_PROCS);
		end else begin
			n_clamp = NW'(active_slots_q);
		end
	end

	assign scan_last = (NW'(cnt_q) + NW'(1)) == n_q;
	assign load_ok   = 32'(slot) < MAX_PROCS;
	assign load_go   = start && (mode == MODE_LOAD);
	assign tick_go   = start && (mode == MODE_TICK);

	// strict compare keeps the lowest slot on a tie
	assign take = vld_s1 && rdy_s1 && (!found_q || (mem_rdata.prio > best_prio_q));

	// picked entries are always ready, so their time is above zero here
	assign t_new = best_time_q - 16'sd1;
	assign p_new = (best_prio_q == PRIO_MIN) ? best_prio_q : best_prio_q - 16'sd1;
	assign fin   = t_new <= 16'sd0;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (tick_go && (n_clamp != '0)) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_WRITE;
			ST_WRITE: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		stat.busy      = 1'b1;
		stat.res_valid = 1'b0;
		res            = '0;
		mem_we         = 1'b0;
		mem_waddr      = best_idx_q;
		mem_wdata      = '{run_time: t_new, prio: p_new};
		mem_re         = 1'b0;
		mem_raddr      = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				stat.busy = 1'b0;
				if (load_go) begin
					stat.res_valid = 1'b1;
					mem_we         = load_ok;
					mem_waddr      = AW'(slot);
					mem_wdata      = '{run_time: run_time, prio: priority_req};
				end else if (tick_go && (n_clamp == '0)) begin
					stat.res_valid = 1'b1;
					res.idle       = 1'b1;
				end
			end
			ST_SCAN: begin
				mem_re = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_WRITE: begin
				stat.res_valid = 1'b1;
				if (found_q) begin
					mem_we           = 1'b1;
					res.picked_slot  = 4'(best_idx_q);
					res.time_left    = t_new;
					res.new_priority = p_new;
					res.finished     = fin;
				end else begin
					res.idle = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			active_slots_q <= '0;
			ready_q        <= '0;
			cnt_q          <= '0;
			n_q            <= '0;
			vld_s1         <= 1'b0;
			found_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_SCAN);
			if (cfg_wr_en) begin
				active_slots_q <= cfg_wr_data;
			end
			if (state_q == ST_IDLE) begin
				cnt_q   <= '0;
				n_q     <= n_clamp;
				found_q <= 1'b0;
				if (load_go && load_ok) begin
					ready_q[AW'(slot)] <= run_time > 16'sd0;
				end
			end
			if (state_q == ST_SCAN) begin
				cnt_q <= cnt_q + AW'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if ((state_q == ST_WRITE) && found_q) begin
				ready_q[best_idx_q] <= !fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q;
		rdy_s1 <= ready_q[cnt_q];
		if (take) begin
			best_idx_q  <= idx_s1;
			best_time_q <= mem_rdata.run_time;
			best_prio_q <= mem_rdata.prio;
		end
	end

endmodule

// ===== hdl/dynamic_priority_scheduler.sv =====
// A load request writes one table slot and returns an all-zero result in the cycle after
// it is taken. A tick request scans slots 0 to n-1 (n = active_slots, capped at MAX_PROCS)
// through the single read port of the entry memory, one slot per cycle, then passes a drain
// state, then writes the winner back (no scan if n is zero). The highest ready priority wins,
// ties go to the lowest slot, and an idle result is given when nothing is ready. Results sit
// in an output register, so a new request is taken while the previous result is removed.
// active_slots may be written only while no request is in flight.
module dynamic_priority_scheduler import dps_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [4:0]         cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               mode,
	input  logic [3:0]         slot,
	input  logic signed [15:0] run_time,
	input  logic signed [15:0] priority_req,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         picked_slot,
	output logic               idle,
	output logic signed [15:0] time_left,
	output logic signed [15:0] new_priority,
	output logic               finished
);

	localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int NW = $clog2(MAX_PROCS + 1);

	ctl_stat_t     stat;
	res_t          res;
	res_t          out_q;
	logic          out_valid_q;
	logic          start;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	assign in_stall = stat.busy || (out_valid_q && out_stall);
	assign start    = in_valid && !in_stall;

	dps_ctrl #(
		.MAX_PROCS (MAX_PROCS),
		.AW        (AW),
		.NW        (NW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.start        (start),
		.mode         (mode),
		.slot         (slot),
		.run_time     (run_time),
		.priority_req (priority_req),
		.stat         (stat),
		.res          (res),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	dps_mem #(
		.DEPTH (MAX_PROCS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// the output slot is always free or being emptied when a result arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign picked_slot  = out_q.picked_slot;
	assign idle         = out_q.idle;
	assign time_left    = out_q.time_left;
	assign new_priority = out_q.new_priority;
	assign finished     = out_q.finished;

endmodule

// ===== hdl/dps_checker.sv =====
// Port-level checks for the dynamic priority scheduler, bound to the top level.
module dps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [3:0]         picked_slot,
	input logic               idle,
	input logic signed [15:0] time_left,
	input logic signed [15:0] new_priority,
	input logic               finished
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(picked_slot) && $stable(time_left))
		else $error("stalled result changed");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle |-> picked_slot == 4'd0 && time_left == 16'sd0 &&
			new_priority == 16'sd0 && !finished)
		else $error("idle result carries data");

	a_fin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> !idle && time_left == 16'sd0)
		else $error("finished entry with time left");

	a_live_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !idle && !finished |-> time_left >= 16'sd0)
		else $error("running entry has negative time");

endmodule

bind dynamic_priority_scheduler dps_checker u_dps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.picked_slot  (picked_slot),
	.idle         (idle),
	.time_left    (time_left),
	.new_priority (new_priority),
	.finished     (finished)
);

// ===== tb/sv/dynamic_priority_scheduler_tb.sv =====
// Self-checking testbench for the dynamic priority scheduler: directed table, then random.
module dynamic_priority_scheduler_tb;
	import dps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS  = 16;
	localparam int LIMIT  = 400000;
	localparam int SETTLE = 24;     // covers the longest tick
	localparam int HOLD   = 400;
	localparam int DIR_N  = 27;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 130;

	localparam res_t ZERO_RES = '0;
	localparam res_t IDLE_RES = '{4'd0, 1'b1, 16'sd0, 16'sd0, 1'b0};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		logic [4:0]         cfg_val;
		logic               m;
		logic [3:0]         s;
		logic signed [15:0] rt;
		logic signed [15:0] pr;
		logic               typed;
		res_t               want;
	} step_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [4:0]         cfg_wr_data;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [3:0]         slot;
	logic signed [15:0] run_time;
	logic signed [15:0] priority_req;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         picked_slot;
	logic               idle;
	logic signed [15:0] time_left;
	logic signed [15:0] new_priority;
	logic               finished;

	// scheduler table as the testbench sees it
	logic signed [15:0] rem_tab [SLOTS];
	logic signed [15:0] prio_tab [SLOTS];
	bit                 ready_tab [SLOTS];
	logic [4:0]         active_cfg;

	res_t sched_q [$];
	int   errors, cyc, sent_cnt, burst_left;
	int   n_load, n_tick, n_idle, n_fin, n_cfg, stall_cyc;
	bit   held;

	step_t dir_tab [DIR_N] = '{
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES},
		'{ROW_CFG, 5'd16, MODE_LOAD, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd0,  16'sh7fff, 16'sh7fff, 1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd15, 16'sd1,   16'sh8000, 1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd5,  16'sd0,   16'sd100, 1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd6,  16'sh8000, 16'sd200, 1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1,
			'{4'd0, 1'b0, 16'sh7ffe, 16'sh7ffe, 1'b0}},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd0,  16'sd2,   16'sh8000, 1'b1, ZERO_RES},
		// both ready slots sit at the priority floor: lowest slot wins, floor holds
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd3,  16'sd5,   16'sd7,   1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd4,  16'sd5,   16'sd7,   1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		// above the table size: treated as the full table
		'{ROW_CFG, 5'd31, MODE_LOAD, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd15, 16'sd3,   16'sd9,   1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_CFG, 5'd4,  MODE_LOAD, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_CFG, 5'd1,  MODE_LOAD, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES},
		'{ROW_REQ, 5'd0,  MODE_LOAD, 4'd1,  -16'sd1,  16'sd5,   1'b1, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES},
		'{ROW_CFG, 5'd0,  MODE_LOAD, 4'd0,  16'sd0,   16'sd0,   1'b0, ZERO_RES},
		'{ROW_REQ, 5'd0,  MODE_TICK, 4'd0,  16'sd0,   16'sd0,   1'b1, IDLE_RES}
	};

	dynamic_priority_scheduler #(.MAX_PROCS(SLOTS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.slot         (slot),
		.run_time     (run_time),
		.priority_req (priority_req),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.picked_slot  (picked_slot),
		.idle         (idle),
		.time_left    (time_left),
		.new_priority (new_priority),
		.finished     (finished)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// next result of the scheduler, updating the table copy
	function automatic res_t schedule_step(input logic m, input logic [3:0] s,
			input logic signed [15:0] rt, input logic signed [15:0] pr);
		res_t               r;
		int                 n, best;
		bit                 found;
		logic signed [15:0] t, p;
		r = '0;
		if (m == MODE_LOAD) begin
			rem_tab[s]   = rt;
			prio_tab[s]  = pr;
			ready_tab[s] = (rt > 0);
			return r;
		end
		n = (int'(active_cfg) > SLOTS) ? SLOTS : int'(active_cfg);
		found = 1'b0;
		best = 0;
		for (int i = 0; i < n; i++) begin
			if (ready_tab[i] && (!found || prio_tab[i] > prio_tab[best])) begin
				best = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			r.idle = 1'b1;
			return r;
		end
		t = rem_tab[best];
		p = prio_tab[best];
		if (t != PRIO_MIN) t = t - 16'sd1;
		if (p != PRIO_MIN) p = p - 16'sd1;
		rem_tab[best]  = t;
		prio_tab[best] = p;
		if (t <= 0) ready_tab[best] = 1'b0;
		r.picked_slot  = best[3:0];
		r.time_left    = t;
		r.new_priority = p;
		r.finished     = (t <= 0);
		return r;
	endfunction

	function automatic void flag(input string fld, input longint want, input longint got);
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, fld, want, got);
		errors++;
	endfunction

	task automatic push_req(input logic m, input logic [3:0] s, input logic signed [15:0] rt,
			input logic signed [15:0] pr, input logic typed, input res_t want);
		res_t calc;
		@(negedge clk);
		in_valid = 1'b1;
		mode = m;
		slot = s;
		run_time = rt;
		priority_req = pr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		calc = schedule_step(m, s, rt, pr);
		sched_q.push_back(typed ? want : calc);
		sent_cnt++;
		if (m == MODE_LOAD) n_load++;
		else n_tick++;
		if (calc.idle) n_idle++;
		if (calc.finished) n_fin++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ?
				$urandom_range(20, 60) : $urandom_range(0, 8);
		end
	endtask

	// only while nothing is in flight
	task automatic set_active(input logic [4:0] v);
		@(negedge clk);
		in_valid = 1'b0;
		while (sched_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		active_cfg = v;
		n_cfg++;
	endtask

	initial begin
		logic               m;
		logic [3:0]         s;
		logic signed [15:0] rt, pr;
		logic [4:0]         ph_cfg;
		int                 sel, tmp;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		slot = '0;
		run_time = '0;
		priority_req = '0;
		active_cfg = '0;
		foreach (ready_tab[i]) ready_tab[i] = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG)
				set_active(dir_tab[i].cfg_val);
			else
				push_req(dir_tab[i].m, dir_tab[i].s, dir_tab[i].rt, dir_tab[i].pr,
					dir_tab[i].typed, dir_tab[i].want);
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: ph_cfg = 5'd16;
				1: ph_cfg = 5'd3;
				2: ph_cfg = 5'd31;
				3: ph_cfg = 5'd0;
				4: ph_cfg = 5'($urandom_range(2, 15));
				default: ph_cfg = 5'd16;
			endcase
			set_active(ph_cfg);
			repeat (PHASE_ITEMS) begin
				m = ($urandom_range(0, 99) < 50) ? MODE_TICK : MODE_LOAD;
				s = 4'($urandom_range(0, 15));
				// mostly short jobs so entries finish, some odd times
				sel = $urandom_range(0, 9);
				if (sel < 8) begin
					rt = 16'($urandom_range(1, 6));
				end else if (sel == 8) begin
					rt = 16'($urandom());
				end else begin
					case ($urandom_range(0, 3))
						0: rt = 16'sd0;
						1: rt = -16'sd1;
						2: rt = 16'sh7fff;
						default: rt = PRIO_MIN;
					endcase
				end
				// narrow priorities give ties
				sel = $urandom_range(0, 9);
				if (sel < 5) begin
					tmp = $urandom_range(0, 6);
					pr = 16'(tmp - 3);
				end else if (sel < 9) begin
					pr = 16'($urandom());
				end else begin
					pr = ($urandom_range(0, 1) == 1) ? 16'sh7fff : PRIO_MIN;
				end
				push_req(m, s, rt, pr, 1'b0, ZERO_RES);
			end
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (sched_q.size() != 0) @(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);
		$display("Ran %0d loads and %0d ticks (%0d idle, %0d jobs ran to completion)",
			n_load, n_tick, n_idle, n_fin);
		$display("over %0d slot-count settings; input was stalled on %0d cycles",
			n_cfg, stall_cyc);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// receiver: random stall stretches plus one long hold-off
	initial begin
		int len, kind;
		out_stall = 1'b0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && sent_cnt > 300) begin
				held = 1'b1;
				@(negedge clk);
				out_stall = 1'b1;
				repeat (HOLD) @(negedge clk);
				out_stall = 1'b0;
			end else begin
				len = $urandom_range(1, 40);
				kind = $urandom_range(0, 2);
				repeat (len) begin
					@(negedge clk);
					case (kind)
						0: out_stall = 1'b0;
						1: out_stall = ($urandom_range(0, 3) == 0);
						default: out_stall = ($urandom_range(0, 3) != 0);
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t want, got;
		if (arst_n && out_valid && !out_stall) begin
			got = '{picked_slot, idle, time_left, new_priority, finished};
			if (sched_q.size() == 0) begin
				$display("%0t: result with nothing expected, got %p", $time, got);
				errors++;
			end else begin
				want = sched_q.pop_front();
				if (got.picked_slot !== want.picked_slot)
					flag("picked_slot", want.picked_slot, got.picked_slot);
				if (got.idle !== want.idle)
					flag("idle", want.idle, got.idle);
				if (got.time_left !== want.time_left)
					flag("time_left", want.time_left, got.time_left);
				if (got.new_priority !== want.new_priority)
					flag("new_priority", want.new_priority, got.new_priority);
				if (got.finished !== want.finished)
					flag("finished", want.finished, got.finished);
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (arst_n && in_valid && in_stall) stall_cyc++;
		if (cyc == LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cyc, sched_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule
